[design/assert_macros.svh]
// Assertion macros shared by the multiply/divide unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition on every clock edge outside reset.
`define HMDU_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define HMDU_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`else

`define HMDU_ASSERT_ALWAYS(lbl, cond, msg)
`define HMDU_ASSERT_NEXT(lbl, trig, cond, msg)

`endif

`endif

[design/hmdu_pkg.sv]
// Types and constants of the HI/LO multiply/divide unit.
package hmdu_pkg;

  localparam int XLEN  = 32;
  localparam int CNT_W = $clog2(XLEN);

  // Operation codes carried by an input transaction
  typedef enum logic [2:0] {
    OP_MULT = 3'd0,
    OP_DIV  = 3'd1,
    OP_MFHI = 3'd2,
    OP_MFLO = 3'd3,
    OP_MTHI = 3'd4,
    OP_MTLO = 3'd5
  } op_e;

  // Top-level sequencing
  typedef enum logic {
    S_IDLE,
    S_BUSY
  } top_state_e;

  // Serial core sequencing
  typedef enum logic [2:0] {
    C_IDLE,
    C_PREP,
    C_RUN,
    C_FIX,
    C_DONE
  } core_state_e;

  // Control from the top level to the serial core
  typedef struct packed {
    logic start;
    logic ack;
    logic divide;
    logic is_signed;
  } core_ctrl_t;

  // Status from the serial core to the top level
  typedef struct packed {
    logic idle;
    logic done;
    logic div_by_zero;
  } core_stat_t;

endpackage

[design/hmdu_in_if.sv]
// Input channel of the multiply/divide unit: operation and operands.
interface hmdu_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic        is_signed;
  logic [31:0] operand_a;
  logic [31:0] operand_b;

  modport source (output valid, output op, output is_signed, output operand_a,
                  output operand_b, input ready);
  modport sink (input valid, input op, input is_signed, input operand_a,
                input operand_b, output ready);
endinterface

[design/hmdu_out_if.sv]
// Output channel of the multiply/divide unit: read data and divide fault flag.
interface hmdu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        divide_by_zero;

  modport source (output valid, output read_data, output divide_by_zero, input ready);
  modport sink (input valid, input read_data, input divide_by_zero, output ready);
endinterface

[design/hmdu_serial_core.sv]
// Radix-2 shift-and-add multiplier and restoring divider sharing one adder.
module hmdu_serial_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hmdu_pkg::core_ctrl_t         ctrl_i,
  input  logic [hmdu_pkg::XLEN-1:0]    operand_a_i,
  input  logic [hmdu_pkg::XLEN-1:0]    operand_b_i,
  output hmdu_pkg::core_stat_t         status_o,
  output logic [hmdu_pkg::XLEN-1:0]    hi_o,
  output logic [hmdu_pkg::XLEN-1:0]    lo_o
);
  import hmdu_pkg::*;

  localparam logic [CNT_W-1:0] LastStep = CNT_W'(XLEN - 1);

  core_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [XLEN:0]    hi_q, hi_d;       // partial product or partial remainder
  logic [XLEN-1:0]  lo_q, lo_d;       // multiplier bits or quotient bits
  logic [XLEN-1:0]  opnd_q, opnd_d;   // multiplicand or divisor
  logic             opnd_top_q, opnd_top_d;
  logic             sgn_q, sgn_d;
  logic             div_q, div_d;
  logic             neg_quo_q, neg_quo_d;
  logic             neg_rem_q, neg_rem_d;
  logic             dz_q, dz_d;

  logic [XLEN+1:0]  add_x, add_y, sum;
  logic [XLEN+1:0]  opnd_ext;
  logic             mul_sub, add_ci;

  function automatic logic [XLEN-1:0] cond_negate(input logic [XLEN-1:0] v,
                                                  input logic en);
    return en ? ((~v) + XLEN'(1)) : v;
  endfunction

  // Shared adder: add or subtract the multiplicand, or trial-subtract the divisor
  assign opnd_ext = {opnd_top_q, opnd_top_q, opnd_q};
  assign mul_sub  = !div_q && sgn_q && (cnt_q == LastStep) && lo_q[0];
  assign add_x    = div_q ? {1'b0, hi_q[XLEN-1:0], lo_q[XLEN-1]} : {hi_q[XLEN], hi_q};
  assign add_y    = div_q ? ~{2'b00, opnd_q} :
                    (lo_q[0] ? (mul_sub ? ~opnd_ext : opnd_ext) : '0);
  assign add_ci   = div_q | mul_sub;
  assign sum      = add_x + add_y + {{(XLEN+1){1'b0}}, add_ci};

  // Sequence the operation one bit per step
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    hi_d       = hi_q;
    lo_d       = lo_q;
    opnd_d     = opnd_q;
    opnd_top_d = opnd_top_q;
    sgn_d      = sgn_q;
    div_d      = div_q;
    neg_quo_d  = neg_quo_q;
    neg_rem_d  = neg_rem_q;
    dz_d       = dz_q;
    unique case (state_q)
      C_IDLE: begin
        if (ctrl_i.start) begin
          sgn_d = ctrl_i.is_signed;
          div_d = ctrl_i.divide;
          cnt_d = '0;
          dz_d  = 1'b0;
          if (!ctrl_i.divide) begin
            hi_d       = '0;
            lo_d       = operand_b_i;
            opnd_d     = operand_a_i;
            opnd_top_d = ctrl_i.is_signed & operand_a_i[XLEN-1];
            state_d    = C_RUN;
          end else if (operand_b_i == '0) begin
            // Zero divisor: all-ones quotient, dividend as remainder
            hi_d    = {1'b0, operand_a_i};
            lo_d    = '1;
            dz_d    = 1'b1;
            state_d = C_DONE;
          end else begin
            hi_d       = '0;
            lo_d       = operand_a_i;
            opnd_d     = operand_b_i;
            opnd_top_d = 1'b0;
            neg_rem_d  = ctrl_i.is_signed & operand_a_i[XLEN-1];
            neg_quo_d  = ctrl_i.is_signed & (operand_a_i[XLEN-1] ^ operand_b_i[XLEN-1]);
            state_d    = C_PREP;
          end
        end
      end
      C_PREP: begin
        // Take magnitudes of dividend and divisor
        lo_d    = cond_negate(lo_q, neg_rem_q);
        opnd_d  = cond_negate(opnd_q, sgn_q & opnd_q[XLEN-1]);
        state_d = C_RUN;
      end
      C_RUN: begin
        if (div_q) begin
          hi_d = sum[XLEN+1] ? {hi_q[XLEN-1:0], lo_q[XLEN-1]} : sum[XLEN:0];
          lo_d = {lo_q[XLEN-2:0], ~sum[XLEN+1]};
        end else begin
          hi_d = sum[XLEN+1:1];
          lo_d = {sum[0], lo_q[XLEN-1:1]};
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == LastStep) begin
          state_d = div_q ? C_FIX : C_DONE;
        end
      end
      C_FIX: begin
        // Restore signs of quotient and remainder
        lo_d    = cond_negate(lo_q, neg_quo_q);
        hi_d    = {1'b0, cond_negate(hi_q[XLEN-1:0], neg_rem_q)};
        state_d = C_DONE;
      end
      C_DONE: begin
        if (ctrl_i.ack) begin
          state_d = C_IDLE;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      cnt_q   <= '0;
      div_q   <= 1'b0;
      sgn_q   <= 1'b0;
      dz_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      div_q   <= div_d;
      sgn_q   <= sgn_d;
      dz_q    <= dz_d;
    end
  end

  // Hold datapath registers
  always_ff @(posedge clk_i) begin
    hi_q       <= hi_d;
    lo_q       <= lo_d;
    opnd_q     <= opnd_d;
    opnd_top_q <= opnd_top_d;
    neg_quo_q  <= neg_quo_d;
    neg_rem_q  <= neg_rem_d;
  end

  assign status_o.idle        = (state_q == C_IDLE);
  assign status_o.done        = (state_q == C_DONE);
  assign status_o.div_by_zero = dz_q;
  assign hi_o                 = hi_q[XLEN-1:0];
  assign lo_o                 = lo_q;

endmodule

[design/hilo_multiply_divide_unit.sv]
// HI/LO multiply/divide unit, top level. Each input transaction carries an
// operation, a signed flag and two 32-bit operands and yields one output
// transaction. Reads and writes of HI and LO load the output register at the
// accepting edge, so they can follow back to back. Multiply runs 32
// shift-and-add steps; divide adds a magnitude step and a sign fix-up step
// around 32 restoring steps; a zero divisor skips all steps. The loop in the
// serial core is radix-2, one bit per cycle through a single 34-bit adder.
// A finished result waits in the core until the output register can take it.
// One operation is in flight at a time, and the next transaction is accepted
// only when the output register is free or draining.
`include "assert_macros.svh"

module hilo_multiply_divide_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  hmdu_in_if.sink    in_if,
  hmdu_out_if.source out_if
);
  import hmdu_pkg::*;

  top_state_e      state_q, state_d;
  logic [XLEN-1:0] hi_q, hi_d;
  logic [XLEN-1:0] lo_q, lo_d;
  logic            out_valid_q, out_valid_d;
  logic [XLEN-1:0] out_data_q, out_data_d;
  logic            out_dz_q, out_dz_d;
  logic            out_free, accept, load_out, is_arith;
  core_ctrl_t      core_ctrl;
  core_stat_t      core_stat;
  logic [XLEN-1:0] core_hi, core_lo;

  hmdu_serial_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (core_ctrl),
    .operand_a_i (in_if.operand_a),
    .operand_b_i (in_if.operand_b),
    .status_o    (core_stat),
    .hi_o        (core_hi),
    .lo_o        (core_lo)
  );

  assign out_free    = !out_valid_q || out_if.ready;
  assign in_if.ready = (state_q == S_IDLE) && out_free;
  assign accept      = in_if.valid && in_if.ready;
  assign is_arith    = (op_e'(in_if.op) == OP_MULT) || (op_e'(in_if.op) == OP_DIV);

  // Decode transactions and sequence the serial core
  always_comb begin
    state_d          = state_q;
    hi_d             = hi_q;
    lo_d             = lo_q;
    load_out         = 1'b0;
    out_data_d       = out_data_q;
    out_dz_d         = out_dz_q;
    core_ctrl.start  = 1'b0;
    core_ctrl.ack    = 1'b0;
    core_ctrl.divide = (op_e'(in_if.op) == OP_DIV);
    core_ctrl.is_signed = in_if.is_signed;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (is_arith) begin
            core_ctrl.start = 1'b1;
            state_d         = S_BUSY;
          end else begin
            load_out   = 1'b1;
            out_data_d = '0;
            out_dz_d   = 1'b0;
            unique case (op_e'(in_if.op))
              OP_MFHI: out_data_d = hi_q;
              OP_MFLO: out_data_d = lo_q;
              OP_MTHI: hi_d = in_if.operand_a;
              OP_MTLO: lo_d = in_if.operand_a;
              default: ;
            endcase
          end
        end
      end
      S_BUSY: begin
        // Retire the core result once the output register can take it
        if (core_stat.done && out_free) begin
          core_ctrl.ack = 1'b1;
          hi_d          = core_hi;
          lo_d          = core_lo;
          load_out      = 1'b1;
          out_data_d    = '0;
          out_dz_d      = core_stat.div_by_zero;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = load_out | (out_valid_q & ~out_if.ready);

  // Hold state, HI, LO and the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      hi_q        <= '0;
      lo_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      hi_q        <= hi_d;
      lo_q        <= lo_d;
    end
  end

  // Hold the output payload
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_dz_q   <= out_dz_d;
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.read_data      = out_data_q;
  assign out_if.divide_by_zero = out_dz_q;

  `HMDU_ASSERT_ALWAYS(a_ready_core_idle, !in_if.ready || core_stat.idle, "ready while core busy")
  `HMDU_ASSERT_NEXT(a_start_busy, accept && is_arith, state_q == S_BUSY, "arith op not started")
  `HMDU_ASSERT_NEXT(a_retire_out, (state_q == S_BUSY) && core_stat.done && out_free, out_valid_q && core_stat.idle, "core result not retired")
  `HMDU_ASSERT_ALWAYS(a_dz_no_data, !(out_valid_q && out_dz_q) || (out_data_q == '0), "fault with read data")

endmodule

[tb/tb_top.sv]
// Self-checking testbench of the HI/LO multiply/divide unit, with a predictor of HI and LO.
module tb_top;
  import hmdu_pkg::*;

  localparam int ITEM_TARGET    = 1350;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 40;
  localparam int IDLE_PCT       = 9;
  localparam int MAX_REPORTS    = 10;
  localparam int DRAIN_EVERY    = 300;

  // Op codes with no operation behind them
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  // One input transaction, plus a flag that holds it back until the unit has drained
  typedef struct packed {
    logic        hold_for_drain;
    logic [2:0]  op;
    logic        is_signed;
    logic [31:0] a;
    logic [31:0] b;
  } mdu_op_t;

  // One output transaction
  typedef struct packed {
    logic [31:0] read_data;
    logic        div_zero;
  } mdu_out_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hmdu_in_if  in_ch ();
  hmdu_out_if out_ch ();

  hilo_multiply_divide_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source)
  );

  mdu_op_t     pending_ops[$];
  mdu_out_t    predicted_out[$];
  logic [31:0] hi_model;
  logic [31:0] lo_model;
  logic        want_drain;
  int          ops_presented;
  int          ops_accepted;
  int          outs_seen;
  int          err_cnt;
  int          quiet_cycles;

  always #10 clk_i = ~clk_i;

  // Work out the output of one operation and advance the HI/LO copy
  function automatic mdu_out_t predict_hilo(mdu_op_t t);
    logic [63:0] ext_a, ext_b, prod;
    logic [31:0] mag_a, mag_b, quo, rem;
    logic        neg_a, neg_b;
    mdu_out_t    r;
    r = '0;
    case (t.op)
      OP_MULT: begin
        ext_a = t.is_signed ? {{32{t.a[31]}}, t.a} : {32'd0, t.a};
        ext_b = t.is_signed ? {{32{t.b[31]}}, t.b} : {32'd0, t.b};
        prod = ext_a * ext_b;
        hi_model = prod[63:32];
        lo_model = prod[31:0];
      end
      OP_DIV: begin
        if (t.b == 32'd0) begin
          // Zero divisor: all-ones quotient, dividend kept as remainder
          lo_model = '1;
          hi_model = t.a;
          r.div_zero = 1'b1;
        end else begin
          neg_a = t.is_signed & t.a[31];
          neg_b = t.is_signed & t.b[31];
          mag_a = neg_a ? (~t.a + 32'd1) : t.a;
          mag_b = neg_b ? (~t.b + 32'd1) : t.b;
          quo = mag_a / mag_b;
          rem = mag_a % mag_b;
          if (neg_a != neg_b) quo = ~quo + 32'd1;
          if (neg_a) rem = ~rem + 32'd1;
          lo_model = quo;
          hi_model = rem;
        end
      end
      OP_MFHI: r.read_data = hi_model;
      OP_MFLO: r.read_data = lo_model;
      OP_MTHI: hi_model = t.a;
      OP_MTLO: lo_model = t.a;
      default: ;
    endcase
    return r;
  endfunction

  // Operand mix weighted toward the corners of the arithmetic
  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5: return 32'($urandom_range(15));
      6: return ~32'($urandom_range(15));
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(logic [2:0] op, logic sgn, logic [31:0] a, logic [31:0] b);
    pending_ops.push_back('{want_drain, op, sgn, a, b});
    want_drain = 1'b0;
  endtask

  task automatic log_fault(string what);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("%s", what);
  endtask

  // No idling on either side over this stretch of the run
  function automatic logic steady_phase();
    return ops_presented >= 500 && ops_presented < 800;
  endfunction

  // Drive input transactions from the pending queue
  always @(posedge clk_i or negedge rst_ni) begin : drive_in
    mdu_op_t nxt;
    if (!rst_ni) begin
      in_ch.valid     <= 1'b0;
      in_ch.op        <= '0;
      in_ch.is_signed <= 1'b0;
      in_ch.operand_a <= '0;
      in_ch.operand_b <= '0;
      ops_presented   <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_ops.size() != 0 &&
          !(pending_ops[0].hold_for_drain && ops_presented != outs_seen) &&
          (steady_phase() || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = pending_ops.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.op        <= nxt.op;
        in_ch.is_signed <= nxt.is_signed;
        in_ch.operand_a <= nxt.a;
        in_ch.operand_b <= nxt.b;
        predicted_out.push_back(predict_hilo(nxt));
        ops_presented <= ops_presented + 1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Count accepted inputs, check output transactions, toggle ready
  always @(posedge clk_i or negedge rst_ni) begin : watch_out
    int       acc_now;
    mdu_out_t got;
    mdu_out_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      ops_accepted <= 0;
      outs_seen    <= 0;
    end else begin
      acc_now = ops_accepted + int'(in_ch.valid && in_ch.ready);
      ops_accepted <= acc_now;
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.read_data, out_ch.divide_by_zero};
        if (outs_seen >= acc_now) begin
          log_fault($sformatf("result %0d: no transaction outstanding, got data %h dz %b",
                              outs_seen, got.read_data, got.div_zero));
        end else begin
          want = predicted_out[outs_seen];
          if (got.read_data !== want.read_data)
            log_fault($sformatf("result %0d: read_data expected %h, got %h",
                                outs_seen, want.read_data, got.read_data));
          if (got.div_zero !== want.div_zero)
            log_fault($sformatf("result %0d: divide_by_zero expected %b, got %b",
                                outs_seen, want.div_zero, got.div_zero));
        end
        outs_seen <= outs_seen + 1;
      end
      out_ch.ready <= steady_phase() || $urandom_range(99) >= IDLE_PCT;
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    logic [2:0] op;
    int         next_drain;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.op        = '0;
    in_ch.is_signed = 1'b0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    out_ch.ready    = 1'b0;
    hi_model        = '0;
    lo_model        = '0;
    want_drain      = 1'b0;
    err_cnt         = 0;
    quiet_cycles    = 0;

    // Directed: reset values, product corners, zero divisor, signed overflow, writes
    queue_op(OP_MFHI, 1'b1, $urandom, $urandom);
    queue_op(OP_MFLO, 1'b0, $urandom, $urandom);
    queue_op(OP_MULT, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_op(OP_MFHI, 1'b0, '0, '0);
    queue_op(OP_MFLO, 1'b0, '0, '0);
    queue_op(OP_MULT, 1'b1, 32'h8000_0000, 32'h8000_0000);
    queue_op(OP_MFHI, 1'b0, '0, '0);
    queue_op(OP_MULT, 1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    queue_op(OP_MFLO, 1'b1, '1, '1);
    queue_op(OP_DIV,  1'b0, 32'hFFFF_FFFF, 32'd0);
    queue_op(OP_MFHI, 1'b0, '0, '0);
    queue_op(OP_MFLO, 1'b0, '0, '0);
    queue_op(OP_DIV,  1'b1, 32'h8000_0000, 32'd0);
    queue_op(OP_MFHI, 1'b0, '0, '0);
    queue_op(OP_DIV,  1'b1, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_op(OP_MFHI, 1'b0, '0, '0);
    queue_op(OP_MFLO, 1'b0, '0, '0);
    queue_op(OP_DIV,  1'b1, 32'hFFFF_FFF9, 32'd2);
    queue_op(OP_MFHI, 1'b0, '0, '0);
    queue_op(OP_MTHI, 1'b0, 32'hA5A5_A5A5, '1);
    queue_op(OP_MTLO, 1'b1, 32'h5A5A_5A5A, '1);
    queue_op(OP_SPARE6, 1'b1, '1, '1);
    queue_op(OP_SPARE7, 1'b0, '1, '1);
    queue_op(OP_MFHI, 1'b0, '0, '0);
    queue_op(OP_MFLO, 1'b0, '0, '0);

    // Random: mostly an update followed by reads, the rest single loose ops
    want_drain = 1'b1;
    next_drain = DRAIN_EVERY;
    while (pending_ops.size() < ITEM_TARGET) begin
      if (pending_ops.size() >= next_drain) begin
        want_drain = 1'b1;
        next_drain += DRAIN_EVERY;
      end
      if ($urandom_range(99) < 70) begin
        case ($urandom_range(5))
          0, 1:    op = OP_MULT;
          2, 3:    op = OP_DIV;
          4:       op = OP_MTHI;
          default: op = OP_MTLO;
        endcase
        queue_op(op, 1'($urandom), pick_word(), pick_word());
        case ($urandom_range(2))
          0: begin
            queue_op(OP_MFHI, 1'($urandom), $urandom, $urandom);
            queue_op(OP_MFLO, 1'($urandom), $urandom, $urandom);
          end
          1: begin
            queue_op(OP_MFLO, 1'($urandom), $urandom, $urandom);
            queue_op(OP_MFHI, 1'($urandom), $urandom, $urandom);
          end
          default: queue_op($urandom_range(1) ? OP_MFHI : OP_MFLO, 1'($urandom),
                            $urandom, $urandom);
        endcase
      end else begin
        queue_op(3'($urandom_range(7)), 1'($urandom), pick_word(), pick_word());
      end
    end

    // Hold reset, then release away from the rising edge
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Drain all stimulus and outstanding results
    while (pending_ops.size() != 0 || in_ch.valid) @(negedge clk_i);
    while (outs_seen != ops_accepted) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (outs_seen != ops_accepted)
      log_fault($sformatf("%0d results still outstanding", ops_accepted - outs_seen));

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[hilo_multiply_divide_unit.f]
+incdir+design
design/hmdu_pkg.sv
design/hmdu_in_if.sv
design/hmdu_out_if.sv
design/hmdu_serial_core.sv
design/hilo_multiply_divide_unit.sv
tb/tb_top.sv
